### design/csss_pkg.sv
package csss_pkg;

    // field and state widths
    localparam int SlotW    = 3;
    localparam int ValueW   = 27;
    localparam int DwellW   = 10;
    localparam int PeriodW  = 16;
    localparam int ElapsedW = 17;
    localparam int DigitW   = 4;
    localparam int SegW     = 8;
    localparam int SelW     = 3;
    localparam int CfgIdxW  = 2;

    // value limits and reset values
    localparam logic [ValueW-1:0]   ValueMax   = 27'd99999999;
    localparam logic [ElapsedW-1:0] ElapsedMax = 17'd131071;
    localparam logic [DwellW-1:0]   DwellRst   = 10'd1;
    localparam logic [PeriodW-1:0]  PeriodRst  = 16'd1000;
    localparam logic [DigitW-1:0]   BlankDigit = 4'd10;

    // divide by ten through a reciprocal multiply
    localparam logic [31:0] DivMagic = 32'hCCCC_CCCD;
    localparam int          DivShift = 35;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgReload  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDwell   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgPeriod  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgReverse = 2'd3;

    // segment patterns, bit0 = a through bit6 = g
    localparam logic [SegW-1:0] SegTable [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // command from the top level to the digit sequencer
    typedef struct packed {
        logic              start;
        logic              ack;
        logic [SlotW-1:0]  slot;
        logic [ValueW-1:0] value;
    } t_seq_cmd;

    // status from the digit sequencer
    typedef struct packed {
        logic              done;
        logic [DigitW-1:0] digit;
    } t_seq_stat;

    // segment pattern of a digit, blank for anything else
    function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
        logic [SegW-1:0] seg;
        seg = '0;
        if (digit < 4'd10) begin
            seg = SegTable[digit];
        end
        return seg;
    endfunction

endpackage

### design/csss_in_if.sv
interface csss_in_if;
    logic valid;
    logic ready;
    logic slot_elapsed;

    modport source (output valid, output slot_elapsed, input ready);
    modport sink   (input valid, input slot_elapsed, output ready);
endinterface

### design/csss_out_if.sv
interface csss_out_if;
    logic                                valid;
    logic                                ready;
    logic [csss_pkg::SelW-1:0]           select_code;
    logic [csss_pkg::SegW-1:0]           segment_pattern;
    logic [csss_pkg::DigitW-1:0]         shown_digit;
    logic [csss_pkg::ValueW-1:0]         display_value;

    modport source (output valid, output select_code, output segment_pattern,
                    output shown_digit, output display_value, input ready);
    modport sink   (input valid, input select_code, input segment_pattern,
                    input shown_digit, input display_value, output ready);
endinterface

### design/countdown_seven_segment_scanner_core.sv
// Multiplexed seven-segment countdown driver. Each tick item yields one
// display item: the tube select code, segment pattern, digit and the value,
// all taken from the state before the tick. The digit of the current
// position is found by a shared divide-by-ten unit that divides once per
// cycle; the display item is held in an output register, and the next tick
// is taken while it waits. Configuration writes go through the plain write
// port and are taken at any time.
module countdown_seven_segment_scanner_core #(
    parameter int DIGITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [csss_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [csss_pkg::ValueW-1:0]    i_cfg_data,
    csss_in_if.sink                        i_tick,
    csss_out_if.source                     o_disp
);
    typedef enum logic [1:0] {
        TP_IDLE = 2'b01,
        TP_BUSY = 2'b10
    } t_top_state;

    localparam logic [csss_pkg::SlotW-1:0] LastSlot = csss_pkg::SlotW'(DIGITS - 1);
    localparam int SumW = csss_pkg::ElapsedW + 1;

    // configuration registers
    logic [csss_pkg::ValueW-1:0]   r_reload;
    logic [csss_pkg::DwellW-1:0]   r_dwell;
    logic [csss_pkg::PeriodW-1:0]  r_period;
    logic                          r_reverse;

    // countdown state
    t_top_state                    r_state, n_state;
    logic [csss_pkg::ValueW-1:0]   r_value, n_value;
    logic [csss_pkg::SlotW-1:0]    r_slot, n_slot;
    logic [csss_pkg::ElapsedW-1:0] r_elapsed, n_elapsed;
    logic                          r_adv;

    // output register
    logic                          r_out_valid;
    logic [csss_pkg::SelW-1:0]     r_sel;
    logic [csss_pkg::SegW-1:0]     r_seg;
    logic [csss_pkg::DigitW-1:0]   r_shown;
    logic [csss_pkg::ValueW-1:0]   r_shown_value;

    csss_pkg::t_seq_cmd            seq_cmd;
    csss_pkg::t_seq_stat           seq_stat;
    logic                          accept;
    logic                          load;
    logic [csss_pkg::SlotW-1:0]    slot_clamp;
    logic [csss_pkg::SlotW-1:0]    tube;
    logic [SumW-1:0]               sum;
    logic [csss_pkg::ElapsedW-1:0] sat;
    logic [csss_pkg::ValueW-1:0]   reload_clamp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= csss_pkg::ValueMax;
            r_dwell   <= csss_pkg::DwellRst;
            r_period  <= csss_pkg::PeriodRst;
            r_reverse <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csss_pkg::CfgReload:  r_reload  <= i_cfg_data;
                csss_pkg::CfgDwell:   r_dwell   <= i_cfg_data[csss_pkg::DwellW-1:0];
                csss_pkg::CfgPeriod:  r_period  <= i_cfg_data[csss_pkg::PeriodW-1:0];
                csss_pkg::CfgReverse: r_reverse <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshakes
    assign i_tick.ready = (r_state == TP_IDLE);
    assign accept       = i_tick.valid && i_tick.ready;
    assign load         = (r_state == TP_BUSY) && seq_stat.done
                          && (!r_out_valid || o_disp.ready);

    // position clamp and tube mapping
    assign slot_clamp = (r_slot > LastSlot) ? LastSlot : r_slot;
    assign tube       = r_reverse ? (LastSlot - slot_clamp) : slot_clamp;

    // digit sequencer
    assign seq_cmd.start = accept;
    assign seq_cmd.ack   = load;
    assign seq_cmd.slot  = slot_clamp;
    assign seq_cmd.value = r_value;

    csss_digit_seq u_digit_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (seq_cmd),
        .o_stat  (seq_stat)
    );

    // elapsed time, saturating
    assign sum = SumW'(r_elapsed) + SumW'(r_dwell);
    assign sat = (sum > SumW'(csss_pkg::ElapsedMax))
                 ? csss_pkg::ElapsedMax : sum[csss_pkg::ElapsedW-1:0];
    assign reload_clamp = (r_reload > csss_pkg::ValueMax) ? csss_pkg::ValueMax : r_reload;

    // state update when the item's result is handed over
    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_slot    = r_slot;
        n_elapsed = r_elapsed;
        case (r_state)
            TP_IDLE: begin
                if (accept) begin
                    n_state = TP_BUSY;
                end
            end
            TP_BUSY: begin
                if (load) begin
                    n_state = TP_IDLE;
                    if (r_adv) begin
                        n_elapsed = sat;
                        if (r_slot >= LastSlot) begin
                            n_slot = '0;
                            if (sat >= csss_pkg::ElapsedW'(r_period)) begin
                                n_elapsed = '0;
                                n_value   = (r_value <= csss_pkg::ValueW'(1))
                                            ? reload_clamp : r_value - 1'b1;
                            end
                        end else begin
                            n_slot = r_slot + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = TP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= TP_IDLE;
            r_value   <= csss_pkg::ValueMax;
            r_slot    <= '0;
            r_elapsed <= '0;
        end else begin
            r_state   <= n_state;
            r_value   <= n_value;
            r_slot    <= n_slot;
            r_elapsed <= n_elapsed;
        end
    end

    // item flag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_adv <= i_tick.slot_elapsed;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_disp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_sel         <= csss_pkg::SelW'(3'd7 - tube);
            r_seg         <= csss_pkg::seg_of(seq_stat.digit);
            r_shown       <= seq_stat.digit;
            r_shown_value <= r_value;
        end
    end

    assign o_disp.valid           = r_out_valid;
    assign o_disp.select_code     = r_sel;
    assign o_disp.segment_pattern = r_seg;
    assign o_disp.shown_digit     = r_shown;
    assign o_disp.display_value   = r_shown_value;

    // the countdown never leaves the eight-digit range
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_value <= csss_pkg::ValueMax)
        else $error("countdown above range");

    // a blank position shows no segments and only a blank shows none
    a_blank_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_shown == csss_pkg::BlankDigit) == (r_seg == '0)))
        else $error("blank and segments disagree");

    // the sequencer holds a digit only while an item is at work
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.done |-> r_state == TP_BUSY)
        else $error("digit finished while idle");

    // the position stays in range
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LastSlot)
        else $error("slot out of range");
endmodule

### design/csss_div10.sv
module csss_div10 (
    input  logic [csss_pkg::ValueW-1:0] i_value,
    output logic [csss_pkg::ValueW-1:0] o_quot,
    output logic [csss_pkg::DigitW-1:0] o_rem
);
    localparam int ProdW = csss_pkg::ValueW + 32;

    logic [ProdW-1:0]            prod;
    logic [csss_pkg::ValueW-1:0] quot_x10;
    logic [csss_pkg::ValueW-1:0] diff;

    // quotient from the reciprocal product
    assign prod   = ProdW'(i_value) * ProdW'(csss_pkg::DivMagic);
    assign o_quot = csss_pkg::ValueW'(prod >> csss_pkg::DivShift);

    // remainder as value minus eight and two times the quotient
    assign quot_x10 = (o_quot << 3) + (o_quot << 1);
    assign diff     = i_value - quot_x10;
    assign o_rem    = diff[csss_pkg::DigitW-1:0];
endmodule

### design/csss_digit_seq.sv
module csss_digit_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csss_pkg::t_seq_cmd  i_cmd,
    output csss_pkg::t_seq_stat o_stat
);
    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_RUN  = 3'b010,
        SQ_DONE = 3'b100
    } t_seq_state;

    t_seq_state                   r_state, n_state;
    logic [csss_pkg::ValueW-1:0]  r_value, n_value;
    logic [csss_pkg::SlotW-1:0]   r_cnt, n_cnt;
    logic [csss_pkg::DigitW-1:0]  r_digit, n_digit;
    logic [csss_pkg::ValueW-1:0]  quot;
    logic [csss_pkg::DigitW-1:0]  rem;

    // shared divide-by-ten unit
    csss_div10 u_div10 (
        .i_value (r_value),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    // one division per cycle until the wanted position sits lowest
    always_comb begin
        n_state = r_state;
        n_value = r_value;
        n_cnt   = r_cnt;
        n_digit = r_digit;
        case (r_state)
            SQ_IDLE: begin
                if (i_cmd.start) begin
                    n_value = i_cmd.value;
                    n_cnt   = i_cmd.slot;
                    n_state = SQ_RUN;
                end
            end
            SQ_RUN: begin
                if (r_cnt != '0) begin
                    n_value = quot;
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_digit = (r_value == '0) ? csss_pkg::BlankDigit : rem;
                    n_state = SQ_DONE;
                end
            end
            SQ_DONE: begin
                if (i_cmd.ack) begin
                    n_state = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_value <= n_value;
        r_cnt   <= n_cnt;
        r_digit <= n_digit;
    end

    assign o_stat.done  = (r_state == SQ_DONE);
    assign o_stat.digit = r_digit;

    // a finished digit is a decimal digit or the blank code
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == SQ_DONE |-> r_digit <= csss_pkg::BlankDigit)
        else $error("digit out of range");

    // start is only given while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == SQ_IDLE)
        else $error("start while busy");

    // the count only falls while running
    a_cnt_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_RUN && r_cnt != '0) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("count did not step");
endmodule
